// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the field accumulator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define DSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Flag a condition that must never be seen outside reset
`define DSF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- hw/rtl/dsfa_pkg.sv -----
package dsfa_pkg;

  localparam int MaxRays   = 4096;
  localparam int RayAw     = $clog2(MaxRays);
  localparam int CntW      = RayAw + 1;
  localparam int PhaseBits = 12;
  localparam int TrigDepth = 1 << PhaseBits;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EVAL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_DRAIN = 2'd2,
    ST_OUT   = 2'd3
  } eval_state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] offset_or_time;
    logic signed [31:0] time_rate;
    logic signed [23:0] gain;
    logic signed [15:0] pol_x;
    logic signed [15:0] pol_y;
    logic signed [15:0] pol_z;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] field_x_re;
    logic signed [47:0] field_x_im;
    logic signed [47:0] field_y_re;
    logic signed [47:0] field_y_im;
    logic signed [47:0] field_z_re;
    logic signed [47:0] field_z_im;
  } out_item_t;

  // point handed from front to back
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [32:0] dt;
    logic [CntW-1:0]    count;
  } eval_cmd_t;

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic signed [31:0] offs;
    logic signed [31:0] rate;
    logic signed [23:0] gain;
    logic signed [15:0] polx;
    logic signed [15:0] poly;
    logic signed [15:0] polz;
  } ray_t;

  localparam logic signed [47:0] AccMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] AccMin = {1'b1, {47{1'b0}}};

  function automatic logic signed [63:0] asr_floor(input logic signed [63:0] v,
                                                   input int n);
    asr_floor = v >>> n;
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32767) r = -64'sd32767;
    to_q15 = r[15:0];
  endfunction

  // cosine and sine of idx / 2^PhaseBits cycle, Q1.15, packed {cos, sin}
  function automatic logic [31:0] trig_value(input logic [PhaseBits-1:0] idx);
    logic [31:0] angle;
    logic [1:0] q;
    logic signed [63:0] x, y, z, dx, dy;
    logic signed [63:0] at [16];
    logic signed [15:0] cx, sy, c, s;
    at = '{64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
           64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
           64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
           64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861};
    angle = {idx, {(32-PhaseBits){1'b0}}};
    q = angle[31:30];
    z = {34'd0, angle[29:0]};
    x = 64'sd652032874;
    y = 64'sd0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - at[i];
      end else begin
        x = x + dx; y = y - dy; z = z + at[i];
      end
    end
    cx = to_q15(x);
    sy = to_q15(y);
    case (q)
      2'd0:    begin c = cx;  s = sy;  end
      2'd1:    begin c = -sy; s = cx;  end
      2'd2:    begin c = -cx; s = -sy; end
      default: begin c = sy;  s = -cx; end
    endcase
    trig_value = {c, s};
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                 input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s > 49'sd140737488355327) sat_add = AccMax;
    else if (s < -49'sd140737488355328) sat_add = AccMin;
    else sat_add = s[47:0];
  endfunction

endpackage

// ----- hw/rtl/debye_sum_field_accumulator_unit.sv -----
// Debye field accumulator.
// Input queue side: push/full with item_i. Opcode load appends a ray,
// clear empties the table, evaluate sums all stored rays at a point.
// Result queue side: empty/pop with result_o, one word per evaluate.
// Loads are always accepted. An evaluate waits only while the two-entry command
// queue is full; a clear waits until every queued evaluate has finished.
// The back end reads the stored rays one a cycle from the ray memory and
// pipelines phase, trig and accumulation for each evaluate.
// Reset empties the table, zeroes time_offset and drops queued work.
// A result not popped holds the back end, the queue fills, then full.
// APB register 0 at address 0: time_offset.
module debye_sum_field_accumulator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsfa_pkg::in_item_t  item_i,
  input  logic                push,
  output logic                full,
  output dsfa_pkg::out_item_t result_o,
  output logic                empty,
  input  logic                pop,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic signed [31:0] toff_q;
  logic ray_we;
  logic [dsfa_pkg::RayAw-1:0] ray_waddr;
  dsfa_pkg::ray_t ray_wdata;
  logic cmd_wr, cmd_rdy, cmd_v, cmd_pop;
  logic back_idle;
  dsfa_pkg::eval_cmd_t cmd_w, cmd_r;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? toff_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) toff_q <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) toff_q <= pwdata;
  end

  dsfa_front u_front (
    .clk_i, .rst_ni, .item_i, .push_i(push), .full_o(full),
    .time_offset_i(toff_q), .evals_busy_i(cmd_v || !back_idle),
    .ray_we_o(ray_we), .ray_waddr_o(ray_waddr),
    .ray_wdata_o(ray_wdata), .cmd_valid_o(cmd_wr), .cmd_o(cmd_w),
    .cmd_ready_i(cmd_rdy)
  );

  dsfa_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(cmd_wr), .wdata_i(cmd_w), .ready_o(cmd_rdy),
    .valid_o(cmd_v), .rdata_o(cmd_r), .rd_i(cmd_pop)
  );

  dsfa_back u_back (
    .clk_i, .rst_ni, .ray_we_i(ray_we), .ray_waddr_i(ray_waddr),
    .ray_wdata_i(ray_wdata), .cmd_valid_i(cmd_v), .cmd_i(cmd_r),
    .cmd_pop_o(cmd_pop), .idle_o(back_idle), .empty_o(empty),
    .result_o(result_o), .pop_i(pop)
  );
endmodule

// ----- hw/rtl/dsfa_front.sv -----
// Accepts items, writes rays, forwards evaluate commands to the queue.
module dsfa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dsfa_pkg::in_item_t       item_i,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic signed [31:0]       time_offset_i,
  input  logic                     evals_busy_i,
  output logic                     ray_we_o,
  output logic [dsfa_pkg::RayAw-1:0] ray_waddr_o,
  output dsfa_pkg::ray_t           ray_wdata_o,
  output logic                     cmd_valid_o,
  output dsfa_pkg::eval_cmd_t      cmd_o,
  input  logic                     cmd_ready_i
);
  logic [dsfa_pkg::CntW-1:0] count_q, count_d;
  logic acc;
  dsfa_pkg::op_e op;

  assign op = dsfa_pkg::op_e'(item_i.opcode);
  // an evaluate stalls when the queue is full; hold a clear until queued
  // evaluates have swept the table, so later loads cannot overwrite their rays
  assign full_o = ((op == dsfa_pkg::OP_EVAL) && !cmd_ready_i) ||
                  ((op == dsfa_pkg::OP_CLEAR) && evals_busy_i);
  assign acc = push_i && !full_o;

  always_comb begin
    count_d = count_q;
    if (acc) begin
      case (op)
        dsfa_pkg::OP_LOAD:
          if (count_q != dsfa_pkg::CntW'(dsfa_pkg::MaxRays)) count_d = count_q + 1'b1;
        dsfa_pkg::OP_CLEAR: count_d = '0;
        default: count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else count_q <= count_d;
  end

  assign ray_we_o = acc && (op == dsfa_pkg::OP_LOAD) &&
                    (count_q != dsfa_pkg::CntW'(dsfa_pkg::MaxRays));
  assign ray_waddr_o = count_q[dsfa_pkg::RayAw-1:0];
  assign ray_wdata_o = '{wx: item_i.vec_x, wy: item_i.vec_y, wz: item_i.vec_z,
                         offs: item_i.offset_or_time, rate: item_i.time_rate,
                         gain: item_i.gain, polx: item_i.pol_x,
                         poly: item_i.pol_y, polz: item_i.pol_z};

  assign cmd_valid_o = acc && (op == dsfa_pkg::OP_EVAL);
  assign cmd_o = '{px: item_i.vec_x, py: item_i.vec_y, pz: item_i.vec_z,
                   dt: {item_i.offset_or_time[31], item_i.offset_or_time}
                       - {time_offset_i[31], time_offset_i},
                   count: count_q};
endmodule

// ----- hw/rtl/dsfa_cmd_fifo.sv -----
`include "assert_macros.svh"
// Two-entry command queue between front and back.
module dsfa_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  dsfa_pkg::eval_cmd_t wdata_i,
  output logic                ready_o,
  output logic                valid_o,
  output dsfa_pkg::eval_cmd_t rdata_o,
  input  logic                rd_i
);
  dsfa_pkg::eval_cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  `DSF_ASSERT(a_no_overflow, wr_i |-> ready_o)
  `DSF_ASSERT(a_no_underflow, rd_i |-> valid_o)
  `DSF_ASSERT_NEVER(a_count_range, cnt_q == 2'd3)
endmodule

// ----- hw/rtl/dsfa_back.sv -----
`include "assert_macros.svh"
// Sweeps the ray table for one point, one ray a cycle, through a short pipeline.
module dsfa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ray_we_i,
  input  logic [dsfa_pkg::RayAw-1:0] ray_waddr_i,
  input  dsfa_pkg::ray_t             ray_wdata_i,
  input  logic                       cmd_valid_i,
  input  dsfa_pkg::eval_cmd_t        cmd_i,
  output logic                       cmd_pop_o,
  output logic                       idle_o,
  output logic                       empty_o,
  output dsfa_pkg::out_item_t        result_o,
  input  logic                       pop_i
);
  dsfa_pkg::ray_t ray_mem [dsfa_pkg::MaxRays];
  logic [31:0] trig_rom [dsfa_pkg::TrigDepth];
  dsfa_pkg::eval_state_e st_q, st_d;
  logic [dsfa_pkg::CntW-1:0] idx_q, idx_d;
  dsfa_pkg::eval_cmd_t cmd_q;
  logic rd_en;
  dsfa_pkg::ray_t ray_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  // stage 2: products
  logic signed [63:0] mx_q, my_q, mz_q, mo_q, mt_q;
  dsfa_pkg::ray_t r2_q, r3_q;
  logic [31:0] ph_q;
  logic signed [15:0] c4_q, s4_q;
  dsfa_pkg::ray_t r4_q;
  logic signed [39:0] gs_q, gc_q;
  logic signed [15:0] p5x_q, p5y_q, p5z_q;
  logic signed [47:0] acc_q [6];
  logic signed [47:0] res_q [6];
  logic full_q;
  logic signed [55:0] t [6];
  logic busy;

  // constant cosine/sine table, {cos, sin} per phase step
  initial begin
    for (int i = 0; i < dsfa_pkg::TrigDepth; i++) begin
      trig_rom[i] = dsfa_pkg::trig_value(dsfa_pkg::PhaseBits'(i));
    end
  end

  assign busy = v1_q || v2_q || v3_q || v4_q || v5_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      dsfa_pkg::ST_IDLE:  if (cmd_valid_i) st_d = dsfa_pkg::ST_SWEEP;
      dsfa_pkg::ST_SWEEP: if (idx_q >= cmd_q.count) st_d = dsfa_pkg::ST_DRAIN;
      dsfa_pkg::ST_DRAIN: if (!busy) st_d = dsfa_pkg::ST_OUT;
      dsfa_pkg::ST_OUT:   if (!full_q) st_d = dsfa_pkg::ST_IDLE;
      default: st_d = dsfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idle_o = (st_q == dsfa_pkg::ST_IDLE);
    cmd_pop_o = (st_q == dsfa_pkg::ST_IDLE) && cmd_valid_i;
    rd_en = (st_q == dsfa_pkg::ST_SWEEP) && (idx_q < cmd_q.count);
    idx_d = cmd_pop_o ? '0 : (rd_en ? idx_q + 1'b1 : idx_q);
  end

  always_ff @(posedge clk_i) begin
    if (ray_we_i) ray_mem[ray_waddr_i] <= ray_wdata_i;
    if (rd_en) ray_q <= ray_mem[idx_q[dsfa_pkg::RayAw-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dsfa_pkg::ST_IDLE; idx_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      full_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d;
      v1_q <= rd_en; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      if (st_q == dsfa_pkg::ST_OUT && !full_q) full_q <= 1'b1;
      else if (pop_i && full_q) full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    // multiply ray terms
    mx_q <= 64'(ray_q.wx) * 64'(cmd_q.px);
    my_q <= 64'(ray_q.wy) * 64'(cmd_q.py);
    mz_q <= 64'(ray_q.wz) * 64'(cmd_q.pz);
    mo_q <= 64'(ray_q.offs) <<< 16;
    mt_q <= 64'(cmd_q.dt) * 64'(ray_q.rate);
    r2_q <= ray_q;
    // only the fraction bits matter
    ph_q <= mx_q[31:0] + my_q[31:0] + mz_q[31:0] - mo_q[31:0] - mt_q[31:0];
    r3_q <= r2_q;
    {c4_q, s4_q} <= trig_rom[ph_q[31 -: dsfa_pkg::PhaseBits]];
    r4_q <= r3_q;
    gs_q <= 40'(r4_q.gain) * 40'(s4_q);
    gc_q <= -(40'(r4_q.gain) * 40'(c4_q));
    p5x_q <= r4_q.polx; p5y_q <= r4_q.poly; p5z_q <= r4_q.polz;
    if (cmd_pop_o) begin
      for (int j = 0; j < 6; j++) acc_q[j] <= '0;
    end else if (v5_q) begin
      for (int j = 0; j < 6; j++) acc_q[j] <= dsfa_pkg::sat_add(acc_q[j], 48'(t[j] >>> 15));
    end
    if (st_q == dsfa_pkg::ST_OUT && !full_q) res_q <= acc_q;
  end

  always_comb begin
    t[0] = 56'(gs_q) * 56'(p5x_q);
    t[1] = 56'(gc_q) * 56'(p5x_q);
    t[2] = 56'(gs_q) * 56'(p5y_q);
    t[3] = 56'(gc_q) * 56'(p5y_q);
    t[4] = 56'(gs_q) * 56'(p5z_q);
    t[5] = 56'(gc_q) * 56'(p5z_q);
  end

  assign empty_o = !full_q;
  assign result_o = '{field_x_re: res_q[0], field_x_im: res_q[1],
                      field_y_re: res_q[2], field_y_im: res_q[3],
                      field_z_re: res_q[4], field_z_im: res_q[5]};

  `DSF_ASSERT(a_read_in_sweep, rd_en |-> st_q == dsfa_pkg::ST_SWEEP)
  `DSF_ASSERT(a_idx_bound, st_q == dsfa_pkg::ST_SWEEP |-> idx_q <= cmd_q.count)
  `DSF_ASSERT(a_no_out_busy, st_q == dsfa_pkg::ST_OUT |-> !busy)
endmodule
